### rtl/id_table_find_or_add_with_aging_macros.svh
// assertion helpers used by the table top level
`ifndef ID_TABLE_FIND_OR_ADD_WITH_AGING_MACROS_SVH
`define ID_TABLE_FIND_OR_ADD_WITH_AGING_MACROS_SVH

// same-cycle implication
`define IDTAB_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("id table assertion failed");

// next-cycle implication
`define IDTAB_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("id table assertion failed");

`endif

### rtl/idtab_pkg.sv
package idtab_pkg;

    localparam int ID_W  = 32;
    localparam int TMR_W = 8;

    // actions
    localparam logic [2:0] ACT_FIND  = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_TICK  = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;
    localparam logic [2:0] ACT_SELF  = 3'd4;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ADDED     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_SELF_ID      = 2'd0;
    localparam logic [1:0] CFG_ALIVE_RELOAD = 2'd1;
    localparam logic [1:0] CFG_LOW_VOLT     = 2'd2;
    localparam logic [1:0] CFG_STORAGE_LOW  = 2'd3;

    // register reset values
    localparam logic [7:0]  RST_ALIVE_RELOAD = 8'd120;
    localparam logic [15:0] RST_LOW_VOLT     = 16'd11500;
    localparam logic [7:0]  RST_STORAGE_LOW  = 8'd230;

    typedef enum logic [1:0] {
        OP_FIND,
        OP_READ,
        OP_TICK
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic done;
    } tok_ctrl_t;

endpackage

### rtl/idtab_cell.sv
module idtab_cell #(
    parameter int CELL_IDX = 1,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [CNT_W-1:0]           used,
    input  logic [idtab_pkg::TMR_W-1:0] reload,
    input  idtab_pkg::tok_ctrl_t       in_ctrl,
    input  logic [IDX_W-1:0]           in_idx,
    input  logic [idtab_pkg::ID_W-1:0]  in_id,
    input  logic [idtab_pkg::TMR_W-1:0] in_timer,
    output idtab_pkg::tok_ctrl_t       out_ctrl,
    output logic [IDX_W-1:0]           out_idx,
    output logic [idtab_pkg::ID_W-1:0]  out_id,
    output logic [idtab_pkg::TMR_W-1:0] out_timer
);
    import idtab_pkg::*;

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ID_W-1:0]  id_reg, id_next;
    logic [TMR_W-1:0] timer_reg, timer_next;
    tok_ctrl_t        ctrl_reg, ctrl_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [ID_W-1:0]  tid_reg, tid_next;
    logic [TMR_W-1:0] ttmr_reg, ttmr_next;
    logic             used_here;

    assign used_here = (MY_CNT < used);

    always_comb begin
        id_next    = id_reg;
        timer_next = timer_reg;
        ctrl_next  = in_ctrl;
        idx_next   = in_idx;
        tid_next   = in_id;
        ttmr_next  = in_timer;
        if (in_ctrl.valid) begin
            unique case (in_ctrl.op)
                OP_FIND: begin
                    if (!in_ctrl.done) begin
                        if (used_here && id_reg == in_id) begin
                            timer_next     = reload;
                            ctrl_next.done = 1'b1;
                            idx_next       = MY_IDX;
                            ttmr_next      = reload;
                        end else if (used == MY_CNT) begin
                            // append at the first free entry
                            id_next        = in_id;
                            timer_next     = reload;
                            ctrl_next.done = 1'b1;
                            idx_next       = MY_IDX;
                            ttmr_next      = reload;
                        end
                    end
                end
                OP_READ: begin
                    if (in_idx == MY_IDX) begin
                        tid_next       = id_reg;
                        ttmr_next      = timer_reg;
                        ctrl_next.done = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (used_here && timer_reg != '0) begin
                        timer_next = timer_reg - 1'b1;
                    end
                end
                default: begin
                    ctrl_next = in_ctrl;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        timer_reg <= timer_next;
        idx_reg   <= idx_next;
        tid_reg   <= tid_next;
        ttmr_reg  <= ttmr_next;
    end

    assign out_ctrl  = ctrl_reg;
    assign out_idx   = idx_reg;
    assign out_id    = tid_reg;
    assign out_timer = ttmr_reg;

endmodule

### rtl/id_table_find_or_add_with_aging.sv
// Node ID table, one item at a time. Entry 0 is the own ID and is served by the
// top level: a find that hits it, a read of it or of an unused slot, a clear,
// a self status write or an unknown action has its result registered on
// acceptance and presented from S_HOLD. Entries 1 to TABLE_DEPTH-1 live in a
// chain of cells; a find that misses entry 0, a read of a used slot above 0
// and a tick send a token down the chain, one cell per cycle, and the result
// is taken from the last cell. The next item is accepted once the current
// result is on the output, even while it still waits on m_ready.
module id_table_find_or_add_with_aging #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [31:0] s_node_id,
    input  logic [3:0]  s_slot,
    input  logic [15:0] s_battery_mv,
    input  logic [7:0]  s_storage_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_entry_index,
    output logic [31:0] m_entry_id,
    output logic [7:0]  m_entry_timer,
    output logic [2:0]  m_entry_flags,
    output logic [4:0]  m_entry_count
);
    import idtab_pkg::*;
    `include "id_table_find_or_add_with_aging_macros.svh"

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int NCELL = TABLE_DEPTH - 1;
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int IX_W  = (IDX_W > 4) ? IDX_W : 4;
    localparam int CO_W  = (CNT_W > 5) ? CNT_W : 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    state_t state_reg;

    // configuration
    logic [ID_W-1:0]  self_id_reg;
    logic [TMR_W-1:0] reload_reg;
    logic [15:0]      low_volt_reg;
    logic [7:0]       storage_low_reg;

    // table state held here
    logic [CNT_W-1:0] used_reg;
    logic [15:0]      self_batt_reg;
    logic [7:0]       self_stor_reg;
    logic [TMR_W-1:0] self_timer_reg;

    // pending result
    logic [1:0]       res_status_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic [ID_W-1:0]  res_id_reg;
    logic [TMR_W-1:0] res_timer_reg;
    logic [2:0]       res_flags_reg;

    // chain of cells
    tok_ctrl_t        ch_ctrl  [NCELL+1];
    logic [IDX_W-1:0] ch_idx   [NCELL+1];
    logic [ID_W-1:0]  ch_id    [NCELL+1];
    logic [TMR_W-1:0] ch_timer [NCELL+1];

    tok_ctrl_t        launch_ctrl_reg;
    logic [IDX_W-1:0] launch_idx_reg;
    logic [ID_W-1:0]  launch_id_reg;

    logic             accept;
    logic [CMP_W-1:0] slot_ext;
    logic [CMP_W-1:0] used_ext;
    logic [IX_W-1:0]  res_idx_ext;
    logic [CO_W-1:0]  used_out_ext;
    logic [CNT_W-1:0] end_idx_cnt;
    logic             self_low_volt;
    logic             self_stor_low;
    tok_ctrl_t        end_ctrl;

    assign s_ready       = (state_reg == S_IDLE);
    assign accept        = s_valid && s_ready;
    assign slot_ext      = CMP_W'(s_slot);
    assign used_ext      = CMP_W'(used_reg);
    assign res_idx_ext   = IX_W'(res_idx_reg);
    assign used_out_ext  = CO_W'(used_reg);
    assign end_ctrl      = ch_ctrl[NCELL];
    assign end_idx_cnt   = CNT_W'(ch_idx[NCELL]);
    assign self_low_volt = (self_batt_reg < low_volt_reg);
    assign self_stor_low = (self_stor_reg >= storage_low_reg);

    assign ch_ctrl[0]  = launch_ctrl_reg;
    assign ch_idx[0]   = launch_idx_reg;
    assign ch_id[0]    = launch_id_reg;
    assign ch_timer[0] = '0;

    for (genvar g = 1; g <= NCELL; g++) begin : g_cell
        idtab_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .used      (used_reg),
            .reload    (reload_reg),
            .in_ctrl   (ch_ctrl[g-1]),
            .in_idx    (ch_idx[g-1]),
            .in_id     (ch_id[g-1]),
            .in_timer  (ch_timer[g-1]),
            .out_ctrl  (ch_ctrl[g]),
            .out_idx   (ch_idx[g]),
            .out_id    (ch_id[g]),
            .out_timer (ch_timer[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            self_id_reg     <= '0;
            reload_reg      <= RST_ALIVE_RELOAD;
            low_volt_reg    <= RST_LOW_VOLT;
            storage_low_reg <= RST_STORAGE_LOW;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SELF_ID:      self_id_reg     <= cfg_wdata;
                CFG_ALIVE_RELOAD: reload_reg      <= cfg_wdata[7:0];
                CFG_LOW_VOLT:     low_volt_reg    <= cfg_wdata[15:0];
                CFG_STORAGE_LOW:  storage_low_reg <= cfg_wdata[7:0];
                default:          self_id_reg     <= self_id_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            used_reg        <= CNT_W'(1);
            self_batt_reg   <= '0;
            self_stor_reg   <= '0;
            self_timer_reg  <= '0;
            launch_ctrl_reg <= '0;
            m_valid         <= 1'b0;
        end else begin
            launch_ctrl_reg.valid <= 1'b0;
            if (m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        res_status_reg <= ST_OK;
                        res_idx_reg    <= '0;
                        res_id_reg     <= '0;
                        res_timer_reg  <= '0;
                        res_flags_reg  <= '0;
                        state_reg      <= S_HOLD;
                        unique case (s_action)
                            ACT_FIND: begin
                                if (s_node_id == self_id_reg) begin
                                    self_timer_reg <= reload_reg;
                                    res_id_reg     <= self_id_reg;
                                    res_timer_reg  <= reload_reg;
                                    res_flags_reg  <= {self_stor_low, self_low_volt,
                                                       reload_reg != '0};
                                end else begin
                                    launch_ctrl_reg <= '{valid: 1'b1, op: OP_FIND,
                                                         done: 1'b0};
                                    launch_id_reg   <= s_node_id;
                                    launch_idx_reg  <= '0;
                                    state_reg       <= S_RUN;
                                end
                            end
                            ACT_READ: begin
                                if (slot_ext >= used_ext) begin
                                    res_status_reg <= ST_NOT_FOUND;
                                end else if (s_slot == '0) begin
                                    res_id_reg    <= self_id_reg;
                                    res_timer_reg <= self_timer_reg;
                                    res_flags_reg <= {self_stor_low, self_low_volt,
                                                      self_timer_reg != '0};
                                end else begin
                                    launch_ctrl_reg <= '{valid: 1'b1, op: OP_READ,
                                                         done: 1'b0};
                                    launch_id_reg   <= '0;
                                    launch_idx_reg  <= slot_ext[IDX_W-1:0];
                                    state_reg       <= S_RUN;
                                end
                            end
                            ACT_TICK: begin
                                launch_ctrl_reg <= '{valid: 1'b1, op: OP_TICK, done: 1'b0};
                                launch_id_reg   <= '0;
                                launch_idx_reg  <= '0;
                                state_reg       <= S_RUN;
                            end
                            ACT_CLEAR: begin
                                used_reg <= CNT_W'(1);
                            end
                            ACT_SELF: begin
                                self_batt_reg <= s_battery_mv;
                                self_stor_reg <= s_storage_level;
                            end
                            default: begin
                                state_reg <= S_HOLD;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (end_ctrl.valid) begin
                        state_reg      <= S_HOLD;
                        res_status_reg <= ST_OK;
                        res_idx_reg    <= '0;
                        res_id_reg     <= '0;
                        res_timer_reg  <= '0;
                        res_flags_reg  <= '0;
                        unique case (end_ctrl.op)
                            OP_FIND: begin
                                if (end_ctrl.done) begin
                                    res_idx_reg   <= ch_idx[NCELL];
                                    res_id_reg    <= ch_id[NCELL];
                                    res_timer_reg <= ch_timer[NCELL];
                                    res_flags_reg <= {2'b00, ch_timer[NCELL] != '0};
                                    if (end_idx_cnt == used_reg) begin
                                        res_status_reg <= ST_ADDED;
                                        used_reg       <= used_reg + 1'b1;
                                    end
                                end else begin
                                    res_status_reg <= ST_FULL;
                                end
                            end
                            OP_READ: begin
                                res_idx_reg   <= ch_idx[NCELL];
                                res_id_reg    <= ch_id[NCELL];
                                res_timer_reg <= ch_timer[NCELL];
                                res_flags_reg <= {2'b00, ch_timer[NCELL] != '0};
                            end
                            default: begin
                                res_status_reg <= ST_OK;
                            end
                        endcase
                    end
                end
                S_HOLD: begin
                    if (!m_valid || m_ready) begin
                        m_valid       <= 1'b1;
                        m_status      <= res_status_reg;
                        m_entry_index <= res_idx_ext[3:0];
                        m_entry_id    <= res_id_reg;
                        m_entry_timer <= res_timer_reg;
                        m_entry_flags <= res_flags_reg;
                        m_entry_count <= used_out_ext[4:0];
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `IDTAB_ASSERT_IMP(a_used_range, aclk, aresetn, 1'b1,
        used_reg >= CNT_W'(1) && used_reg <= CNT_W'(TABLE_DEPTH))
    `IDTAB_ASSERT_IMP(a_token_in_run, aclk, aresetn, end_ctrl.valid, state_reg == S_RUN)
    `IDTAB_ASSERT_IMP(a_idle_no_launch, aclk, aresetn, state_reg == S_IDLE,
        !launch_ctrl_reg.valid)
    `IDTAB_ASSERT_NEXT(a_clear_count, aclk, aresetn, accept && s_action == ACT_CLEAR,
        used_reg == CNT_W'(1))

endmodule
